### hw/rtl/nlp_pkg.sv
// ---------------------------------------------------------------------------
// nlp_pkg
// shared types, character codes and the boolean word table of the
// number literal parser
// ---------------------------------------------------------------------------
package nlp_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int ACC_W       = VALUE_WIDTH + 4;
	localparam int OUT_W       = 32;
	localparam int NUM_WORDS   = 8;
	localparam int POS_W       = 3;

	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_MINUS   = 8'h2d;
	localparam logic [7:0] CH_POINT   = 8'h2e;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_ONE     = 8'h31;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_F    = 8'h46;
	localparam logic [7:0] CH_LO_A    = 8'h61;
	localparam logic [7:0] CH_LO_F    = 8'h66;
	localparam logic [7:0] CH_UP_B    = 8'h42;
	localparam logic [7:0] CH_LO_B    = 8'h62;
	localparam logic [7:0] CH_UP_X    = 8'h58;
	localparam logic [7:0] CH_LO_X    = 8'h78;

	// words 0..3 are false, 4..7 are true
	localparam logic [7:0] WORD_TEXT [0:NUM_WORDS-1][0:7] = '{
		'{"0", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"o", "f", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
		'{"n", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"1", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"o", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"y", "e", "s", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [POS_W-1:0] WORD_LEN [0:NUM_WORDS-1] = '{
		3'd1, 3'd3, 3'd5, 3'd2, 3'd1, 3'd2, 3'd4, 3'd3
	};
	localparam int FIRST_TRUE_WORD = 4;

	typedef struct packed {
		logic [3:0] digit;
		logic       is_dec;
		logic       is_hex;
		logic       is_bin;
		logic       is_dollar;
		logic       is_percent;
		logic       is_plus;
		logic       is_minus;
		logic       is_zero;
		logic       is_point;
		logic       is_x;
		logic       is_b;
	} char_class_t;

	typedef struct packed {
		logic                   is_numeric;
		logic [OUT_W-1:0]       number_value;
		logic                   has_point;
		logic                   is_boolean;
		logic                   boolean_value;
	} result_t;

endpackage

### hw/rtl/nlp_decode.sv
// ---------------------------------------------------------------------------
// nlp_decode
// classifies one character: digit value, digit kinds, prefix and sign marks
// ---------------------------------------------------------------------------
module nlp_decode import nlp_pkg::*; (
	input  logic [7:0]  char_code,
	output char_class_t cls
);

	logic dec_r, lo_r, up_r;

	always_comb begin
		dec_r = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		lo_r  = (char_code >= CH_LO_A) && (char_code <= CH_LO_F);
		up_r  = (char_code >= CH_UP_A) && (char_code <= CH_UP_F);
		cls.digit = 4'd0;
		if (dec_r) begin
			cls.digit = 4'(char_code - CH_ZERO);
		end else if (lo_r) begin
			cls.digit = 4'(char_code - CH_LO_A + 8'd10);
		end else if (up_r) begin
			cls.digit = 4'(char_code - CH_UP_A + 8'd10);
		end
		cls.is_dec     = dec_r;
		cls.is_hex     = dec_r || lo_r || up_r;
		cls.is_bin     = (char_code == CH_ZERO) || (char_code == CH_ONE);
		cls.is_dollar  = char_code == CH_DOLLAR;
		cls.is_percent = char_code == CH_PERCENT;
		cls.is_plus    = char_code == CH_PLUS;
		cls.is_minus   = char_code == CH_MINUS;
		cls.is_zero    = char_code == CH_ZERO;
		cls.is_point   = char_code == CH_POINT;
		cls.is_x       = (char_code == CH_LO_X) || (char_code == CH_UP_X);
		cls.is_b       = (char_code == CH_LO_B) || (char_code == CH_UP_B);
	end

endmodule

### hw/rtl/nlp_core.sv
// ---------------------------------------------------------------------------
// nlp_core
// per-token state: format tracker, saturating accumulator, boolean word
// matcher, and the result register
// ---------------------------------------------------------------------------
module nlp_core import nlp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] char_code,
	input  logic       last_char,
	input  logic       res_take,
	output logic       res_valid,
	output result_t    res
);

	typedef enum logic [3:0] {
		ST_START,
		ST_ZERO,
		ST_DEC,
		ST_FRAC,
		ST_HEX,
		ST_BIN,
		ST_BAD
	} fmt_state_t;

	typedef enum logic [1:0] {
		BASE_2,
		BASE_10,
		BASE_16
	} base_t;

	localparam logic [VALUE_WIDTH-1:0] LIMIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic [VALUE_WIDTH-1:0] MAX_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

	fmt_state_t              state_q, state_n;
	logic [VALUE_WIDTH-1:0]  mag_q, mag_n;
	logic                    ovf_q, ovf_n;
	logic                    neg_q, neg_n;
	logic                    point_q, point_n;
	logic [NUM_WORDS-1:0]    cand_q, cand_n;
	logic [POS_W-1:0]        pos_q, pos_n;
	logic                    res_valid_q;
	result_t                 res_q, res_n;

	char_class_t             cls;
	logic                    acc_en;
	base_t                   acc_base;
	logic [ACC_W-1:0]        mag_ext, prod, sum;
	logic [VALUE_WIDTH-1:0]  mag_sel, val_vw;
	logic signed [63:0]      val_ext;
	logic                    numeric, bool_hit, bool_truth;

	nlp_decode u_decode (
		.char_code (char_code),
		.cls       (cls)
	);

	// format tracking
	always_comb begin
		state_n  = state_q;
		neg_n    = neg_q;
		point_n  = point_q;
		acc_en   = 1'b0;
		acc_base = BASE_10;
		unique case (state_q)
			ST_START: begin
				if (cls.is_dollar) begin
					state_n = ST_HEX;
				end else if (cls.is_percent) begin
					state_n = ST_BIN;
				end else if (cls.is_plus || cls.is_minus) begin
					neg_n   = cls.is_minus;
					state_n = ST_DEC;
				end else if (cls.is_zero) begin
					state_n = ST_ZERO;
				end else if (cls.is_dec) begin
					acc_en  = 1'b1;
					state_n = ST_DEC;
				end else begin
					state_n = ST_BAD;
				end
			end
			ST_ZERO: begin
				if (cls.is_x) begin
					state_n = ST_HEX;
				end else if (cls.is_b) begin
					state_n = ST_BIN;
				end else if (cls.is_dec) begin
					acc_en  = 1'b1;
					state_n = ST_DEC;
				end else if (cls.is_point) begin
					point_n = 1'b1;
					state_n = ST_FRAC;
				end else begin
					state_n = ST_BAD;
				end
			end
			ST_DEC: begin
				if (cls.is_dec) begin
					acc_en = 1'b1;
				end else if (cls.is_point) begin
					point_n = 1'b1;
					state_n = ST_FRAC;
				end else begin
					state_n = ST_BAD;
				end
			end
			ST_FRAC: begin
				if (!cls.is_dec) begin
					state_n = ST_BAD;
				end
			end
			ST_HEX: begin
				acc_base = BASE_16;
				if (cls.is_hex) begin
					acc_en = 1'b1;
				end else begin
					state_n = ST_BAD;
				end
			end
			ST_BIN: begin
				acc_base = BASE_2;
				if (cls.is_bin) begin
					acc_en = 1'b1;
				end else begin
					state_n = ST_BAD;
				end
			end
			default: begin
				state_n = ST_BAD;
			end
		endcase
	end

	// saturating accumulate: overflow once mag*base+d passes the limit
	always_comb begin
		mag_ext = {4'b0000, mag_q};
		case (acc_base)
			BASE_2:  prod = mag_ext << 1;
			BASE_16: prod = mag_ext << 4;
			default: prod = (mag_ext << 3) + (mag_ext << 1);
		endcase
		sum   = prod + ACC_W'(cls.digit);
		mag_n = mag_q;
		ovf_n = ovf_q;
		if (acc_en && !ovf_q) begin
			if (sum > {4'b0000, LIMIT}) begin
				ovf_n = 1'b1;
			end else begin
				mag_n = sum[VALUE_WIDTH-1:0];
			end
		end
	end

	// boolean word match
	always_comb begin
		for (int i = 0; i < NUM_WORDS; i++) begin
			cand_n[i] = cand_q[i] && (pos_q < WORD_LEN[i])
				&& (WORD_TEXT[i][pos_q] == char_code);
		end
		pos_n = (pos_q == {POS_W{1'b1}}) ? pos_q : pos_q + 1'b1;
		bool_hit   = 1'b0;
		bool_truth = 1'b0;
		for (int i = NUM_WORDS - 1; i >= 0; i--) begin
			if (cand_n[i] && (WORD_LEN[i] == pos_n)) begin
				bool_hit   = 1'b1;
				bool_truth = (i >= FIRST_TRUE_WORD);
			end
		end
	end

	// result from the updated state
	always_comb begin
		numeric = (state_n != ST_START) && (state_n != ST_BAD);
		mag_sel = ovf_n ? LIMIT : mag_n;
		if (neg_n) begin
			val_vw  = VALUE_WIDTH'(~mag_sel + 1'b1);
		end else begin
			val_vw  = (ovf_n || mag_n[VALUE_WIDTH-1]) ? MAX_POS : mag_n;
		end
		if (!numeric) begin
			val_vw = '0;
		end
		val_ext = 64'(signed'(val_vw));
		res_n.is_numeric    = numeric;
		res_n.number_value  = val_ext[OUT_W-1:0];
		res_n.has_point     = numeric && point_n;
		res_n.is_boolean    = bool_hit;
		res_n.boolean_value = bool_truth;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_START;
			mag_q       <= '0;
			ovf_q       <= 1'b0;
			neg_q       <= 1'b0;
			point_q     <= 1'b0;
			cand_q      <= '1;
			pos_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (step && last_char) begin
				state_q     <= ST_START;
				mag_q       <= '0;
				ovf_q       <= 1'b0;
				neg_q       <= 1'b0;
				point_q     <= 1'b0;
				cand_q      <= '1;
				pos_q       <= '0;
				res_valid_q <= 1'b1;
				res_q       <= res_n;
			end else begin
				if (step) begin
					state_q <= state_n;
					mag_q   <= mag_n;
					ovf_q   <= ovf_n;
					neg_q   <= neg_n;
					point_q <= point_n;
					cand_q  <= cand_n;
					pos_q   <= pos_n;
				end
				if (res_take) begin
					res_valid_q <= 1'b0;
				end
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### hw/rtl/number_literal_parser.sv
// ---------------------------------------------------------------------------
// number_literal_parser
// path: a token's last item passes the input register, then the result register
// throughput: one character item per cycle, as the accumulator updates once
// per item; a last item waits while the previous result is not yet taken
// reset: arst_n clears the token state, the input register and the result
// ---------------------------------------------------------------------------
module number_literal_parser import nlp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code[7:0]
	input  logic        s_tlast,   // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // is_numeric, number_value[31:0], has_point,
	                               // is_boolean, boolean_value, zero pad
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       step;
	logic       res_valid;
	result_t    res;

	// a last char must wait while a previous result is still held
	assign step     = valid_s1 && (!last_s1 || !res_valid || m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			char_s1  <= '0;
			last_s1  <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
				char_s1  <= s_tdata;
				last_s1  <= s_tlast;
			end
		end
	end

	nlp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_code (char_s1),
		.last_char (last_s1),
		.res_take  (m_tready),
		.res_valid (res_valid),
		.res       (res)
	);

	assign m_tvalid = res_valid;
	assign m_tdata  = {4'b0000, res.boolean_value, res.is_boolean, res.has_point,
		res.number_value, res.is_numeric};

endmodule

### bench/tb.sv
// ---------------------------------------------------------------------------
// tb
// stream-level test of number_literal_parser: tokens of characters are sent
// with random gaps, each token result is predicted from a model of the
// literal scanner and the boolean word matcher, and checked field by field
// while the result side stalls at random
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import nlp_pkg::*;

	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          RANDOM_ITEMS = 2000;
	localparam int          TRUE_FROM    = 4;
	localparam longint unsigned SAT_LIMIT = 64'd1 << (VALUE_WIDTH - 1);
	localparam string       HEX_DIGITS   = "0123456789abcdefABCDEF";

	typedef enum logic [2:0] {
		SCAN_START, SCAN_ZERO, SCAN_DEC, SCAN_FRAC, SCAN_HEX, SCAN_BIN, SCAN_BAD
	} scan_state_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;   // char_code[7:0]
	logic        s_tlast  = 1'b0;    // last_char
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;            // is_numeric, number_value[31:0], has_point,
	                                 // is_boolean, boolean_value, zero pad

	string bool_words [0:7] = '{"0", "off", "false", "no", "1", "on", "true", "yes"};

	scan_state_t     scan_state = SCAN_START;
	longint unsigned magnitude  = 0;
	bit              overflowed = 0;
	bit              negative   = 0;
	bit              point_seen = 0;
	logic [7:0]      word_mask  = 8'hff;
	int unsigned     char_pos   = 0;

	result_t     literal_q [$];
	int unsigned sent_chars = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit          quiet_in  = 0;
	bit          quiet_out = 0;

	number_literal_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------- literal prediction ----------------

	function automatic int digit_val(logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
		if (c >= CH_LO_A && c <= CH_LO_F) return int'(c - CH_LO_A) + 10;
		if (c >= CH_UP_A && c <= CH_UP_F) return int'(c - CH_UP_A) + 10;
		return -1;
	endfunction

	function automatic void add_digit(int unsigned base, int unsigned d);
		if (overflowed) return;
		if (magnitude > (SAT_LIMIT - d) / base)
			overflowed = 1;
		else
			magnitude = magnitude * base + d;
	endfunction

	function automatic void clear_token();
		scan_state = SCAN_START;
		magnitude  = 0;
		overflowed = 0;
		negative   = 0;
		point_seen = 0;
		word_mask  = 8'hff;
		char_pos   = 0;
	endfunction

	function automatic void scan_char(logic [7:0] c, logic last);
		int              d;
		bit              dec;
		longint unsigned m;
		logic [63:0]     neg_m;
		result_t         r;
		d   = digit_val(c);
		dec = (d >= 0 && d <= 9);
		case (scan_state)
			SCAN_START: begin
				if (c == CH_DOLLAR) scan_state = SCAN_HEX;
				else if (c == CH_PERCENT) scan_state = SCAN_BIN;
				else if (c == CH_PLUS || c == CH_MINUS) begin
					negative   = (c == CH_MINUS);
					scan_state = SCAN_DEC;
				end else if (c == CH_ZERO) scan_state = SCAN_ZERO;
				else if (dec) begin
					add_digit(10, d);
					scan_state = SCAN_DEC;
				end else scan_state = SCAN_BAD;
			end
			SCAN_ZERO: begin
				if (c == CH_LO_X || c == CH_UP_X) scan_state = SCAN_HEX;
				else if (c == CH_LO_B || c == CH_UP_B) scan_state = SCAN_BIN;
				else if (dec) begin
					add_digit(10, d);
					scan_state = SCAN_DEC;
				end else if (c == CH_POINT) begin
					point_seen = 1;
					scan_state = SCAN_FRAC;
				end else scan_state = SCAN_BAD;
			end
			SCAN_DEC: begin
				if (dec) add_digit(10, d);
				else if (c == CH_POINT) begin
					point_seen = 1;
					scan_state = SCAN_FRAC;
				end else scan_state = SCAN_BAD;
			end
			SCAN_FRAC: begin
				if (!dec) scan_state = SCAN_BAD;
			end
			SCAN_HEX: begin
				if (d >= 0) add_digit(16, d);
				else scan_state = SCAN_BAD;
			end
			SCAN_BIN: begin
				if (d == 0 || d == 1) add_digit(2, d);
				else scan_state = SCAN_BAD;
			end
			default: scan_state = SCAN_BAD;
		endcase

		for (int i = 0; i < 8; i++) begin
			if (char_pos >= bool_words[i].len() || bool_words[i][char_pos] != c)
				word_mask[i] = 1'b0;
		end
		if (char_pos < 7) char_pos++;

		if (!last) return;

		r = '0;
		r.is_numeric = (scan_state != SCAN_BAD && scan_state != SCAN_START);
		if (r.is_numeric) begin
			if (negative) begin
				m     = overflowed ? SAT_LIMIT : magnitude;
				neg_m = ~m + 64'd1;
				r.number_value = neg_m[OUT_W-1:0];
			end else begin
				m = (overflowed || magnitude > SAT_LIMIT - 1) ? SAT_LIMIT - 1 : magnitude;
				r.number_value = m[OUT_W-1:0];
			end
			r.has_point = point_seen;
		end
		for (int i = 0; i < 8; i++) begin
			if (word_mask[i] && bool_words[i].len() == char_pos) begin
				r.is_boolean    = 1'b1;
				r.boolean_value = (i >= TRUE_FROM);
				break;
			end
		end
		literal_q.push_back(r);
		clear_token();
	endfunction

	// ---------------- result checking ----------------

	function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		result_t e;
		if (m_tvalid === 1'b1 && m_tready) begin
			if (literal_q.size() == 0) begin
				$display("%0t: result with none expected, expected none actual %h",
					$time, m_tdata);
				mismatches++;
			end else begin
				e = literal_q.pop_front();
				check_field("is_numeric", 32'(e.is_numeric), 32'(m_tdata[0]));
				check_field("number_value", e.number_value, m_tdata[32:1]);
				check_field("has_point", 32'(e.has_point), 32'(m_tdata[33]));
				check_field("is_boolean", 32'(e.is_boolean), 32'(m_tdata[34]));
				check_field("boolean_value", 32'(e.boolean_value), 32'(m_tdata[35]));
			end
		end
	end

	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0) quiet_out = !quiet_out;
			stall = quiet_out ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
		end
	end

	// ---------------- stimulus ----------------

	task automatic send_char(input logic [7:0] c, input logic last);
		int unsigned gap;
		gap = quiet_in ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		do @(posedge clk); while (s_tready !== 1'b1);
		scan_char(c, last);
		sent_chars++;
	endtask

	task automatic send_token(input logic [7:0] tok [$]);
		foreach (tok[i]) send_char(tok[i], i == tok.size() - 1);
	endtask

	function automatic void put_text(ref logic [7:0] tok [$], input string s);
		for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
	endfunction

	task automatic send_text(input string s);
		logic [7:0] tok [$];
		put_text(tok, s);
		send_token(tok);
	endtask

	function automatic int unsigned draw_len();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
	endfunction

	function automatic void put_decimal(ref logic [7:0] tok [$]);
		int unsigned sign_sel, n;
		longint      v;
		sign_sel = $urandom_range(0, 2);
		if (sign_sel == 1) tok.push_back(CH_PLUS);
		if (sign_sel == 2) tok.push_back(CH_MINUS);
		// values around the saturation point
		if ($urandom_range(0, 9) == 0) begin
			v = 64'd2147483646 + $urandom_range(0, 3);
			put_text(tok, $sformatf("%0d", v));
		end else begin
			n = draw_len();
			repeat (n) tok.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
		end
		if ($urandom_range(0, 3) == 0) begin
			tok.push_back(CH_POINT);
			n = $urandom_range(0, 4);
			repeat (n) tok.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
		end
		if (tok.size() == 0) tok.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
	endfunction

	function automatic void put_radix(ref logic [7:0] tok [$], input bit hex);
		int unsigned n;
		case ($urandom_range(0, 2))
			0: tok.push_back(hex ? CH_DOLLAR : CH_PERCENT);
			1: begin
				tok.push_back(CH_ZERO);
				tok.push_back(hex ? CH_LO_X : CH_LO_B);
			end
			default: begin
				tok.push_back(CH_ZERO);
				tok.push_back(hex ? CH_UP_X : CH_UP_B);
			end
		endcase
		if (hex && $urandom_range(0, 7) == 0) begin
			put_text(tok, $urandom_range(0, 1) ? "7FFFFFFF" : "80000000");
		end else begin
			n = draw_len();
			repeat (n) begin
				if (hex) tok.push_back(HEX_DIGITS[$urandom_range(0, 21)]);
				else tok.push_back(8'(CH_ZERO + $urandom_range(0, 1)));
			end
		end
	endfunction

	function automatic void put_word(ref logic [7:0] tok [$]);
		string s;
		s = bool_words[$urandom_range(0, 7)];
		case ($urandom_range(0, 5))
			0: if (s.len() > 1) s = s.substr(0, s.len() - 2);
			1: s = {s, "s"};
			2: s = s.toupper();
			default: ;
		endcase
		put_text(tok, s);
	endfunction

	function automatic void make_token(ref logic [7:0] tok [$]);
		int unsigned kind, n;
		kind = $urandom_range(0, 99);
		if (kind < 22) put_decimal(tok);
		else if (kind < 40) put_radix(tok, 1);
		else if (kind < 55) put_radix(tok, 0);
		else if (kind < 70) put_word(tok);
		else if (kind < 85) begin
			// well-formed literal with one character spoiled
			if ($urandom_range(0, 1)) put_decimal(tok);
			else put_radix(tok, 1'($urandom_range(0, 1)));
			tok[$urandom_range(0, tok.size() - 1)] = 8'($urandom_range(0, 255));
		end else begin
			n = $urandom_range(1, 8);
			repeat (n) tok.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	// ---------------- tests ----------------

	task automatic test_special_forms();
		send_text("$");
		send_text("%");
		send_text("0x");
		send_text("-");
		send_text("0b2");
		send_text("-.5");
		send_text("0.");
		send_char(8'h00, 1'b1);
		send_char(8'hff, 1'b1);
	endtask

	task automatic test_boolean_words();
		send_text("yes");
		send_text("off");
		send_text("0");
		send_text("1");
		send_text("no");
	endtask

	task automatic test_random_tokens();
		logic [7:0]  tok [$];
		int unsigned stop_at;
		stop_at = sent_chars + RANDOM_ITEMS;
		while (sent_chars < stop_at) begin
			tok.delete();
			make_token(tok);
			if ($urandom_range(0, 7) == 0) quiet_in = !quiet_in;
			send_token(tok);
		end
		quiet_in = 0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_forms();
		test_boolean_words();
		test_random_tokens();
		s_tvalid <= 1'b0;
		while (literal_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
